// ===== src/assert_macros.svh =====
// Assertion macros for the box filter RTL.
// Used by modules that have clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/bf3_pkg.sv =====
// Package for the 3x3 box filter: defaults, register codes, coefficient
// and the window control struct. No dependencies.
package bf3_pkg;

	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int MAX_CHANNELS_DEF = 4;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 16;
	localparam int CHAN_REG_BITS   = 3;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_INDEX_BITS  = 2;

	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd480;
	localparam logic [CHAN_REG_BITS-1:0]   CHAN_RESET   = 3'd1;

	localparam int WIN_SIZE = 3;

	localparam int COEF_BITS  = 15;
	localparam int COEF_SHIFT = 16;
	localparam logic signed [COEF_BITS-1:0] COEF_NUM = 15'sd7274;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_IMAGE_HEIGHT  = 2'd1,
		CFG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                     shift;
		logic [CHAN_REG_BITS-1:0] head;
	} win_ctrl_t;

endpackage

// ===== src/bf3_if.sv =====
// Stream interfaces of the box filter: sample input and filtered output.
// Valid/ready handshake; depends on nothing.
interface bf3_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink (input valid, input in_sample, output ready);
endinterface

interface bf3_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          out_last;

	modport source (output valid, output out_sample, output out_last, input ready);
	modport sink (input valid, input out_sample, input out_last, output ready);
endinterface

// ===== src/bf3_cell.sv =====
// One window cell: holds a column sum and passes it to its neighbour.
// Depends on nothing.
module bf3_cell #(
	parameter int VAL_W = 18
) (
	input  logic                    clk,
	input  logic                    shift,
	input  logic                    take_new,
	input  logic signed [VAL_W-1:0] new_val,
	input  logic signed [VAL_W-1:0] next_val,
	output logic signed [VAL_W-1:0] val
);

	logic signed [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= take_new ? new_val : next_val;
		end
	end

	assign val = val_q;

endmodule

// ===== src/bf3_window.sv =====
// Chain of column-sum cells giving the sums one and two pixels back for
// the current channel. Depends on bf3_pkg and bf3_cell.
module bf3_window
	import bf3_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int VAL_W        = 18
) (
	input  logic                    clk,
	input  win_ctrl_t               ctrl,
	input  logic signed [VAL_W-1:0] col_sum,
	output logic signed [VAL_W-1:0] tap_near,
	output logic signed [VAL_W-1:0] tap_far
);

	localparam int CELLS = 2 * MAX_CHANNELS;

	logic signed [VAL_W-1:0] cell_val [CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam int POS = i % MAX_CHANNELS;
		logic signed [VAL_W-1:0] inj;
		logic signed [VAL_W-1:0] nxt;

		assign inj = (i < MAX_CHANNELS) ? col_sum : cell_val[0];
		assign nxt = (i == CELLS - 1) ? cell_val[i] : cell_val[(i + 1) % CELLS];

		bf3_cell #(.VAL_W(VAL_W)) u_cell (
			.clk      (clk),
			.shift    (ctrl.shift),
			.take_new (32'(ctrl.head) == POS),
			.new_val  (inj),
			.next_val (nxt),
			.val      (cell_val[i])
		);
	end

	assign tap_near = cell_val[0];
	assign tap_far  = cell_val[MAX_CHANNELS];

endmodule

// ===== src/box_filter_3x3_multichannel.sv =====
// Top level of the 3x3 valid-region box filter over interleaved channels.
// Depends on bf3_pkg, bf3_if, bf3_window and assert_macros.svh.
//
//   channel   | role                 | payload
//   samples   | raster sample input  | in_sample
//   filtered  | averaged output      | out_sample, out_last
//   cfg_*     | register write port  | cfg_index, cfg_data
//
// One sample per cycle sustained while the output is ready; a transfer passes
// the registered stages line store read, sum and window, coefficient multiply.
// The two line stores are single-write RAMs read once per transfer.
// Border samples produce no result but still update stores and window.
// Reset clears position counters and restores register defaults; stores
// need no clearing. Output stalls back up stage by stage to samples.ready.
`include "assert_macros.svh"

module box_filter_3x3_multichannel
	import bf3_pkg::*;
#(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	bf3_in_if.sink                    samples,
	bf3_out_if.source                 filtered,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_SUM_W = SB + 2;
	localparam int SUM_W  = SB + 4;
	localparam int PROD_W = SUM_W + COEF_BITS;

	logic [WIDTH_REG_BITS-1:0]  width_q;
	logic [HEIGHT_REG_BITS-1:0] height_q;
	logic [CHAN_REG_BITS-1:0]   chans_q;
	logic [WIDTH_REG_BITS-1:0]  eff_w;
	logic [HEIGHT_REG_BITS-1:0] eff_h;
	logic [CHAN_REG_BITS-1:0]   eff_c;

	logic [COL_W-1:0]           col_q;
	logic [HEIGHT_REG_BITS-1:0] row_q;
	logic [CH_W-1:0]            ch_q;
	logic [ADDR_W-1:0]          col_base_q;
	logic [ADDR_W-1:0]          rd_addr;
	logic                       last_ch;
	logic                       last_col;
	logic                       last_row;

	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic accept;
	logic leave1;

	logic [SB-1:0] upper_mem [DEPTH];
	logic [SB-1:0] lower_mem [DEPTH];

	logic                    valid_s1;
	logic signed [SB-1:0]    top_s1;
	logic signed [SB-1:0]    mid_s1;
	logic signed [SB-1:0]    bot_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic                    produce_s1;
	logic                    last_s1;

	logic                        valid_s2;
	logic signed [SUM_W-1:0]     sum_s2;
	logic                        last_s2;
	logic                        valid_s3;
	logic signed [PROD_W-1:0]    prod_s3;
	logic                        last_s3;

	logic signed [COL_SUM_W-1:0] col_sum;
	logic signed [COL_SUM_W-1:0] tap_near;
	logic signed [COL_SUM_W-1:0] tap_far;
	win_ctrl_t                   win_ctrl;

	always_comb begin
		if (width_q < WIDTH_REG_BITS'(WIN_SIZE)) begin
			eff_w = WIDTH_REG_BITS'(WIN_SIZE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WIDTH_REG_BITS'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q < HEIGHT_REG_BITS'(WIN_SIZE)) ? HEIGHT_REG_BITS'(WIN_SIZE) : height_q;
		if (chans_q == '0) begin
			eff_c = CHAN_REG_BITS'(1);
		end else if (32'(chans_q) > MAX_CHANNELS) begin
			eff_c = CHAN_REG_BITS'(MAX_CHANNELS);
		end else begin
			eff_c = chans_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			chans_q  <= CHAN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:   width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				CFG_IMAGE_HEIGHT:  height_q <= cfg_data[HEIGHT_REG_BITS-1:0];
				CFG_CHANNEL_COUNT: chans_q  <= cfg_data[CHAN_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign last_ch  = (32'(ch_q) + 1) >= 32'(eff_c);
	assign last_col = (32'(col_q) + 1) >= 32'(eff_w);
	assign last_row = (32'(row_q) + 1) >= 32'(eff_h);
	assign rd_addr  = col_base_q + ADDR_W'(ch_q);

	assign rdy3   = !valid_s3 || filtered.ready;
	assign rdy2   = !valid_s2 || rdy3;
	assign rdy1   = !valid_s1 || rdy2;
	assign accept = samples.valid && rdy1;
	assign leave1 = valid_s1 && rdy2;
	assign samples.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			ch_q       <= '0;
			col_base_q <= '0;
		end else if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT
				|| cfg_index == CFG_CHANNEL_COUNT)) begin
			col_q      <= '0;
			row_q      <= '0;
			ch_q       <= '0;
			col_base_q <= '0;
		end else if (accept) begin
			if (!last_ch) begin
				ch_q <= ch_q + CH_W'(1);
			end else begin
				ch_q <= '0;
				if (!last_col) begin
					col_q      <= col_q + COL_W'(1);
					col_base_q <= col_base_q + ADDR_W'(MAX_CHANNELS);
				end else begin
					col_q      <= '0;
					col_base_q <= '0;
					row_q      <= last_row ? '0 : row_q + HEIGHT_REG_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= upper_mem[rd_addr];
			mid_s1 <= lower_mem[rd_addr];
		end
		if (leave1) begin
			upper_mem[addr_s1] <= mid_s1;
			lower_mem[addr_s1] <= bot_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bot_s1     <= samples.in_sample;
			addr_s1    <= rd_addr;
			produce_s1 <= (row_q >= HEIGHT_REG_BITS'(2)) && (col_q >= COL_W'(2));
			last_s1    <= last_ch && last_col && last_row;
		end
		if (rdy2) begin
			sum_s2  <= SUM_W'(col_sum) + SUM_W'(tap_near) + SUM_W'(tap_far);
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'(COEF_NUM);
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= samples.valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1 && produce_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign col_sum = COL_SUM_W'(top_s1) + COL_SUM_W'(mid_s1) + COL_SUM_W'(bot_s1);

	assign win_ctrl.shift = leave1;
	assign win_ctrl.head  = eff_c - CHAN_REG_BITS'(1);

	bf3_window #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.VAL_W        (COL_SUM_W)
	) u_window (
		.clk      (clk),
		.ctrl     (win_ctrl),
		.col_sum  (col_sum),
		.tap_near (tap_near),
		.tap_far  (tap_far)
	);

	assign filtered.valid      = valid_s3;
	assign filtered.out_sample = prod_s3[COEF_SHIFT +: SB];
	assign filtered.out_last   = last_s3;

	`ASSERT_NEVER(a_mem_hazard, accept && leave1 && (rd_addr == addr_s1))
	`ASSERT_NEVER(a_chan_range, 32'(ch_q) >= 32'(eff_c))
	`ASSERT_NEVER(a_col_range, 32'(col_q) >= 32'(eff_w))
	`ASSERT_NEVER(a_base_sync, 32'(col_base_q) != 32'(col_q) * MAX_CHANNELS)
	`ASSERT_PROP(a_frame_wrap, accept && last_ch && last_col && last_row |=> (row_q == '0 && col_q == '0))

endmodule

// ===== sim/tb_box_filter_3x3_multichannel.sv =====
// Testbench for box_filter_3x3_multichannel: a directed table, then random frames under
// bursty input and a stalling output, each result checked against a local predictor or a table value.
// Depends on bf3_pkg, bf3_if and the RTL of the filter.
module tb_box_filter_3x3_multichannel;
	import bf3_pkg::*;

	localparam int MAX_CH     = MAX_CHANNELS_DEF;
	localparam int MAX_W      = MAX_WIDTH_DEF;
	localparam int LINE_DEPTH = MAX_W * MAX_CH;
	localparam int LATENCY    = 3;
	localparam int RANDOM_ITEMS = 1130;
	localparam int LONG_HOLD  = 400;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NO_REGISTER = 2'd3;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} average_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CFG_INDEX_BITS-1:0] reg_index;
		logic [15:0]               value;
		average_t                  known;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	bf3_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) sample_ch ();
	bf3_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) filt_ch ();

	box_filter_3x3_multichannel DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (sample_ch),
		.filtered (filt_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic signed [15:0] upper_row [LINE_DEPTH];
	logic signed [15:0] lower_row [LINE_DEPTH];
	logic signed [15:0] win [MAX_CH][2][3];
	int unsigned col_pos, row_pos, chan_pos;
	logic [WIDTH_REG_BITS-1:0]  width_reg;
	logic [HEIGHT_REG_BITS-1:0] height_reg;
	logic [CHAN_REG_BITS-1:0]   chan_reg;

	average_t   awaited_averages [$];
	table_row_t directed_table [$];
	int mismatch_count = 0;
	int burst_left = 0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;

	function automatic int unsigned eff_width();
		if (width_reg < 3) return 3;
		if (width_reg > MAX_W) return MAX_W;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < 3) ? 3 : 32'(height_reg);
	endfunction

	function automatic int unsigned eff_channels();
		if (chan_reg < 1) return 1;
		if (chan_reg > MAX_CH) return MAX_CH;
		return 32'(chan_reg);
	endfunction

	task automatic box_average_step(input logic signed [15:0] s, input bit typed,
			input average_t typed_avg);
		int unsigned w, h, c, addr;
		logic signed [15:0] top, mid;
		longint sum, prod;
		bit last_ch, last_col, last_row;
		average_t avg;
		w = eff_width();
		h = eff_height();
		c = eff_channels();
		addr = col_pos * MAX_CH + chan_pos;
		top = upper_row[addr];
		mid = lower_row[addr];
		sum = longint'(top) + longint'(mid) + longint'(s);
		for (int k = 0; k < 2; k++)
			for (int r = 0; r < 3; r++)
				sum += longint'(win[chan_pos][k][r]);
		last_ch = (chan_pos + 1 >= c);
		last_col = (col_pos + 1 >= w);
		last_row = (row_pos + 1 >= h);
		if (row_pos >= 2 && col_pos >= 2) begin
			prod = (sum * longint'(COEF_NUM)) >>> COEF_SHIFT;
			avg.sample = prod[15:0];
			avg.last = last_ch && last_col && last_row;
			awaited_averages = {awaited_averages, (typed ? typed_avg : avg)};
		end
		upper_row[addr] = mid;
		lower_row[addr] = s;
		for (int r = 0; r < 3; r++)
			win[chan_pos][0][r] = win[chan_pos][1][r];
		win[chan_pos][1][0] = top;
		win[chan_pos][1][1] = mid;
		win[chan_pos][1][2] = s;
		if (!last_ch) begin
			chan_pos++;
		end else begin
			chan_pos = 0;
			if (!last_col) begin
				col_pos++;
			end else begin
				col_pos = 0;
				row_pos = last_row ? 0 : row_pos + 1;
			end
		end
	endtask

	task automatic offer_sample(input logic signed [15:0] s, input bit typed,
			input average_t typed_avg);
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.in_sample <= s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		box_average_step(s, typed, typed_avg);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
		end
	endtask

	task automatic paced_sample(input logic signed [15:0] s);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 8));
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		offer_sample(s, 1'b0, '0);
	endtask

	// hold the input until every result is out and the pipeline has settled
	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (awaited_averages.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_IMAGE_WIDTH:   width_reg = data[WIDTH_REG_BITS-1:0];
			CFG_IMAGE_HEIGHT:  height_reg = data[HEIGHT_REG_BITS-1:0];
			CFG_CHANNEL_COUNT: chan_reg = data[CHAN_REG_BITS-1:0];
			default: ;
		endcase
		if (idx != CFG_NO_REGISTER) begin
			col_pos = 0;
			row_pos = 0;
			chan_pos = 0;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_row(input row_kind_t kind, input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [15:0] value, input average_t known);
		table_row_t row;
		row.kind = kind;
		row.reg_index = idx;
		row.value = value;
		row.known = known;
		directed_table = {directed_table, row};
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int unsigned random_items, phase, n, frame_len, r;
		logic [15:0] w_val, h_val, c_val;
		random_items = 0;
		phase = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.in_sample = '0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			upper_row[i] = '0;
			lower_row[i] = '0;
		end
		for (int ch = 0; ch < MAX_CH; ch++)
			for (int k = 0; k < 2; k++)
				for (int j = 0; j < 3; j++)
					win[ch][k][j] = '0;
		col_pos = 0;
		row_pos = 0;
		chan_pos = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		chan_reg = CHAN_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// out-of-range registers clamp to a 3x3 single-channel frame
		add_row(ROW_WRITE, CFG_IMAGE_WIDTH, 16'd0, '0);
		add_row(ROW_WRITE, CFG_IMAGE_HEIGHT, 16'd2, '0);
		add_row(ROW_WRITE, CFG_CHANNEL_COUNT, 16'd0, '0);
		repeat (8) add_row(ROW_SAMPLE, '0, 16'h7FFF, '0);
		add_row(ROW_CHECKED, '0, 16'h7FFF, '{16'sd32732, 1'b1});
		repeat (4) add_row(ROW_SAMPLE, '0, 16'h8000, '0);
		// a write to no register must leave the position untouched
		add_row(ROW_WRITE, CFG_NO_REGISTER, 16'hFFFF, '0);
		repeat (4) add_row(ROW_SAMPLE, '0, 16'h8000, '0);
		add_row(ROW_CHECKED, '0, 16'h8000, '{-16'sd32733, 1'b1});

		foreach (directed_table[i]) begin
			case (directed_table[i].kind)
				ROW_WRITE: begin
					drain();
					cfg_write(directed_table[i].reg_index, directed_table[i].value);
				end
				ROW_SAMPLE:  offer_sample(directed_table[i].value, 1'b0, '0);
				ROW_CHECKED: offer_sample(directed_table[i].value, 1'b1,
					directed_table[i].known);
				default: ;
			endcase
		end

		while (random_items < RANDOM_ITEMS || phase <= 2) begin
			drain();
			if (phase == 0) begin
				// one wide single-channel frame
				cfg_write(CFG_IMAGE_WIDTH, 16'd120);
				cfg_write(CFG_IMAGE_HEIGHT, 16'd3);
				cfg_write(CFG_CHANNEL_COUNT, 16'd1);
				n = eff_width() * eff_height() * eff_channels();
				random_items += n;
			end else begin
				r = $urandom_range(0, 9);
				w_val = (r == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 8));
				r = $urandom_range(0, 9);
				h_val = (r == 0) ? 16'($urandom_range(0, 2)) :
					(r == 1) ? 16'($urandom_range(6, 16)) : 16'($urandom_range(3, 5));
				r = $urandom_range(0, 3);
				c_val = ($urandom_range(0, 5) == 0) ? ((r == 0) ? 16'd0 : 16'(r + 4)) :
					16'($urandom_range(1, 4));
				if (phase == 2) begin
					w_val = 8;
					h_val = 5;
					c_val = 4;
				end
				if (phase <= 2 || $urandom_range(0, 3) != 0)
					cfg_write(CFG_IMAGE_WIDTH, w_val);
				if (phase <= 2 || $urandom_range(0, 3) != 0)
					cfg_write(CFG_IMAGE_HEIGHT, h_val);
				if (phase <= 2 || $urandom_range(0, 3) != 0)
					cfg_write(CFG_CHANNEL_COUNT, c_val);
				frame_len = eff_width() * eff_height() * eff_channels();
				n = frame_len * $urandom_range(1, 2);
				if (phase == 2) begin
					n = 2 * frame_len;
					hold_request = 1'b1;
				end else if ($urandom_range(0, 4) == 0) begin
					n = $urandom_range(1, n);
				end
				random_items += n;
			end
			repeat (n)
				paced_sample(pick_sample());
			phase++;
		end

		drain();
		if (mismatch_count == 0 && awaited_averages.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : receiver_pace
		int mode, mode_left, hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		filt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				filt_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					0: filt_ch.ready <= 1'b1;
					1: filt_ch.ready <= 1'($urandom_range(0, 1));
					default: filt_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		average_t got, want;
		if (arst_n && filt_ch.valid && filt_ch.ready) begin
			got.sample = filt_ch.out_sample;
			got.last = filt_ch.out_last;
			if (awaited_averages.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected transfer: sample %0d last %0b",
						got.sample, got.last);
			end else begin
				want = awaited_averages.pop_front();
				if (got.sample !== want.sample || got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
							want.sample, want.last, got.sample, got.last);
				end
			end
		end
	end

	initial begin : watchdog
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
